/* design/klpr_pkg.sv */
// Package for the key long-press remapper: field widths, register
// indexes, stream layout constants and the result entry type.
// No dependencies.
package klpr_pkg;

  localparam int CODE_W      = 10;
  localparam int TICKS_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TDATA_W     = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_UP_CODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_DOWN_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_CODE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_CODE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MENU_CODE        = 3'd5;

  // Register reset values
  localparam logic [TICKS_W-1:0] RST_LONG_PRESS_TICKS = 16'd1000;
  localparam logic [CODE_W-1:0]  RST_VOL_UP_CODE      = 10'd115;
  localparam logic [CODE_W-1:0]  RST_VOL_DOWN_CODE    = 10'd114;
  localparam logic [CODE_W-1:0]  RST_HOME_CODE        = 10'd102;
  localparam logic [CODE_W-1:0]  RST_BACK_CODE        = 10'd158;
  localparam logic [CODE_W-1:0]  RST_MENU_CODE        = 10'd139;

  // Input kind carried on in_tuser
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic              last;
    logic              value;
    logic [CODE_W-1:0] code;
  } result_t;

endpackage

/* design/key_long_press_remapper.sv */
// Top level of the key long-press remapper: state update, config
// registers and a small result queue feeding the output stream.
// Depends on klpr_pkg.
//
//  channel | dir  | handshake          | payload
//  --------+------+--------------------+-------------------------------------------
//  in_     | in   | in_tvalid/tready   | tdata: key_code, pressed; tuser: mode
//  out_    | out  | out_tvalid/tready  | tdata: event_code, event_value; tlast: last
//  cfg_    | in   | cfg_valid/ready    | cfg_index, cfg_data
//
// One item per cycle while in_tready is high: an accepted item updates the key state in the same
// cycle and pushes 0, 1 or 2 results into a 4-entry result queue.
// Results leave the queue one per cycle while out_tready is high, so items that make two results
// can be taken no faster than the output port drains those results.
// in_tready is high while the queue has room for two results.
// Reset (rst_n low, synchronous) restores register defaults, clears the
// key state and empties the queue. cfg_ready is always high.
module key_long_press_remapper #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [klpr_pkg::TDATA_W-1:0]        in_tdata,   // [9:0] key_code, [10] pressed
  input  logic [0:0]                          in_tuser,   // [0] mode
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [klpr_pkg::TDATA_W-1:0]        out_tdata,  // [9:0] event_code, [10] event_value
  output logic                                out_tlast,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [klpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [klpr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import klpr_pkg::*;

  // Width used to clamp the tick setting into the counter range
  localparam int LW = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;
  localparam logic [LW-1:0] CMAX = LW'({COUNT_BITS{1'b1}});

  // Config registers
  logic [TICKS_W-1:0] long_ticks_r;
  logic [CODE_W-1:0]  vol_up_code_r, vol_down_code_r;
  logic [CODE_W-1:0]  home_code_r, back_code_r, menu_code_r;

  // Key state
  logic                  up_held_r, up_held_nxt;
  logic                  down_held_r, down_held_nxt;
  logic                  up_mark_r, up_mark_nxt;
  logic                  down_mark_r, down_mark_nxt;
  logic [COUNT_BITS-1:0] up_cd_r, up_cd_nxt;
  logic [COUNT_BITS-1:0] down_cd_r, down_cd_nxt;

  // Result queue
  result_t           queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QPTR_W-1:0] tail_r, tail_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  logic              in_acc, out_acc;
  logic              mode;
  logic [CODE_W-1:0] key_code;
  logic              pressed;
  logic              is_up, is_down;
  logic              up_exp, down_exp, fire;
  logic [LW-1:0]     ticks_ext;
  logic [COUNT_BITS-1:0] arm_val;
  logic [COUNT_BITS-1:0] up_dec, down_dec;
  result_t           res0, res1;
  logic [1:0]        n_res;
  logic              fire_up, fire_lvl;
  logic [CODE_W-1:0] fire_code;

  assign mode     = in_tuser[0];
  assign key_code = in_tdata[CODE_W-1:0];
  assign pressed  = in_tdata[CODE_W];

  assign in_tready = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_acc   = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;

  assign out_tdata = {{(TDATA_W - CODE_W - 1){1'b0}}, queue_r[head_r].value,
                      queue_r[head_r].code};
  assign out_tlast = queue_r[head_r].last;

  // Arm value: zero setting arms with one, saturate at counter max
  always_comb begin
    ticks_ext = LW'(long_ticks_r);
    if (ticks_ext == '0) begin
      arm_val = COUNT_BITS'(1);
    end else if (ticks_ext > CMAX) begin
      arm_val = CMAX[COUNT_BITS-1:0];
    end else begin
      arm_val = ticks_ext[COUNT_BITS-1:0];
    end
  end

  assign up_exp   = (up_cd_r == COUNT_BITS'(1));
  assign down_exp = (down_cd_r == COUNT_BITS'(1));
  assign up_dec   = (up_cd_r != '0) ? up_cd_r - COUNT_BITS'(1) : up_cd_r;
  assign down_dec = (down_cd_r != '0) ? down_cd_r - COUNT_BITS'(1) : down_cd_r;
  assign fire     = (mode == MODE_TICK) && (up_exp || down_exp);
  // up wins when both expire on the same tick
  assign fire_up  = up_exp;
  assign fire_lvl = fire_up ? up_held_r : down_held_r;

  assign is_up   = (key_code == vol_up_code_r);
  assign is_down = !is_up && (key_code == vol_down_code_r);

  always_comb begin
    if (up_held_r && down_held_r) begin
      fire_code = menu_code_r;
    end else if (fire_up) begin
      fire_code = home_code_r;
    end else begin
      fire_code = back_code_r;
    end
  end

  // State update and results for the accepted item
  always_comb begin
    up_held_nxt   = up_held_r;
    down_held_nxt = down_held_r;
    up_mark_nxt   = up_mark_r;
    down_mark_nxt = down_mark_r;
    up_cd_nxt     = up_cd_r;
    down_cd_nxt   = down_cd_r;
    res0          = '0;
    res1          = '0;
    n_res         = 2'd0;
    if (in_acc) begin
      if (mode == MODE_TICK) begin
        up_cd_nxt   = up_dec;
        down_cd_nxt = down_dec;
        if (fire) begin
          up_cd_nxt   = '0;
          down_cd_nxt = '0;
          if (up_held_r && down_held_r) begin
            up_mark_nxt   = 1'b1;
            down_mark_nxt = 1'b1;
          end else if (fire_up) begin
            up_mark_nxt = 1'b1;
          end else begin
            down_mark_nxt = 1'b1;
          end
          // first event carries the held level, second its inverse
          res0  = '{last: 1'b0, value: fire_lvl,  code: fire_code};
          res1  = '{last: 1'b1, value: !fire_lvl, code: fire_code};
          n_res = 2'd2;
        end
      end else if (!is_up && !is_down) begin
        // other keys pass straight through
        res0  = '{last: 1'b1, value: pressed, code: key_code};
        n_res = 2'd1;
      end else begin
        if (is_up) up_held_nxt = pressed;
        else       down_held_nxt = pressed;
        if (pressed) begin
          if (is_up) up_cd_nxt = arm_val;
          else       down_cd_nxt = arm_val;
        end else if (is_up ? up_mark_r : down_mark_r) begin
          // release after a long press only clears the mark
          if (is_up) up_mark_nxt = 1'b0;
          else       down_mark_nxt = 1'b0;
        end else begin
          // short press: report press then release of the key itself
          if (is_up) up_cd_nxt = '0;
          else       down_cd_nxt = '0;
          res0  = '{last: 1'b0, value: 1'b1, code: key_code};
          res1  = '{last: 1'b1, value: 1'b0, code: key_code};
          n_res = 2'd2;
        end
      end
    end
  end

  assign tail_nxt  = tail_r + QPTR_W'(n_res);
  assign head_nxt  = out_acc ? head_r + QPTR_W'(1) : head_r;
  assign count_nxt = count_r + QCNT_W'(n_res) - QCNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r    <= RST_LONG_PRESS_TICKS;
      vol_up_code_r   <= RST_VOL_UP_CODE;
      vol_down_code_r <= RST_VOL_DOWN_CODE;
      home_code_r     <= RST_HOME_CODE;
      back_code_r     <= RST_BACK_CODE;
      menu_code_r     <= RST_MENU_CODE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LONG_PRESS_TICKS: long_ticks_r    <= cfg_data;
        REG_VOL_UP_CODE:      vol_up_code_r   <= cfg_data[CODE_W-1:0];
        REG_VOL_DOWN_CODE:    vol_down_code_r <= cfg_data[CODE_W-1:0];
        REG_HOME_CODE:        home_code_r     <= cfg_data[CODE_W-1:0];
        REG_BACK_CODE:        back_code_r     <= cfg_data[CODE_W-1:0];
        REG_MENU_CODE:        menu_code_r     <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_held_r   <= 1'b0;
      down_held_r <= 1'b0;
      up_mark_r   <= 1'b0;
      down_mark_r <= 1'b0;
      up_cd_r     <= '0;
      down_cd_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
    end else begin
      up_held_r   <= up_held_nxt;
      down_held_r <= down_held_nxt;
      up_mark_r   <= up_mark_nxt;
      down_mark_r <= down_mark_nxt;
      up_cd_r     <= up_cd_nxt;
      down_cd_r   <= down_cd_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
    end
  end

  // Queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) queue_r[tail_r] <= res0;
    if (n_res == 2'd2) queue_r[tail_r + QPTR_W'(1)] <= res1;
  end

  // Queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // An item is only taken with room for all of its results
  a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (count_r + QCNT_W'(n_res) <= QCNT_W'(QUEUE_DEPTH)))
    else $error("item accepted without queue room");

  // The first of a pair is always followed by its partner already queued
  a_pair_intact: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_tlast) |-> (count_r >= QCNT_W'(2)))
    else $error("split result pair");

  // Long press fire disarms both countdowns
  a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && fire) |=> (up_cd_r == '0 && down_cd_r == '0))
    else $error("countdown still armed after long press");

endmodule

/* sim/tb_key_long_press_remapper.sv */
// Testbench for key_long_press_remapper: scoreboard against an in-bench model of the
// volume-key long-press logic, directed and random key/tick items, stalls on both streams.
// Depends on klpr_pkg and the key_long_press_remapper RTL.
module tb_key_long_press_remapper;
  import klpr_pkg::*;

  // index of the two volume keys in the model's per-key arrays
  localparam int VOL_UP   = 0;
  localparam int VOL_DOWN = 1;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic              mode;
    logic [CODE_W-1:0] code;
    logic              pressed;
  } key_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  key_long_press_remapper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Key model: registers and per-key state, updated on accepted items
  // ---------------------------------------------------------------------------
  logic [TICKS_W-1:0] long_ticks;
  logic [CODE_W-1:0]  vol_code [2];
  logic [CODE_W-1:0]  home_code, back_code, menu_code;
  logic               held [2];
  logic               long_mark [2];
  logic [TICKS_W-1:0] ticks_left [2];

  result_t   expected_events[$];
  key_item_t pending_items[$];

  int errors        = 0;
  int items_taken   = 0;
  int events_seen   = 0;
  int cfg_writes    = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  logic in_taken = 1'b0;

  task automatic emit_event(input logic [CODE_W-1:0] code, input logic value,
                            input logic last);
    result_t ev;
    ev.code  = code;
    ev.value = value;
    ev.last  = last;
    expected_events.push_back(ev);
  endtask

  // countdown of key k ran out: remap, mark, disarm both keys
  task automatic fire_long_press(input int k);
    logic [CODE_W-1:0] code;
    logic lvl;
    lvl = held[k];
    if (held[VOL_UP] && held[VOL_DOWN]) begin
      code = menu_code;
      long_mark[VOL_UP]   = 1'b1;
      long_mark[VOL_DOWN] = 1'b1;
    end else begin
      code = (k == VOL_UP) ? home_code : back_code;
    end
    long_mark[k] = 1'b1;
    ticks_left[VOL_UP]   = '0;
    ticks_left[VOL_DOWN] = '0;
    // first event carries the held level, the second its inverse
    emit_event(code, lvl, 1'b0);
    emit_event(code, !lvl, 1'b1);
  endtask

  task automatic remap_key_item(input key_item_t it);
    logic up_runs_out, down_runs_out;
    int k;
    if (it.mode == MODE_TICK) begin
      up_runs_out   = (ticks_left[VOL_UP] == 1);
      down_runs_out = (ticks_left[VOL_DOWN] == 1);
      for (k = 0; k < 2; k++)
        if (ticks_left[k] != 0) ticks_left[k] = ticks_left[k] - 1'b1;
      // up has priority when both run out on the same tick
      if (up_runs_out) fire_long_press(VOL_UP);
      else if (down_runs_out) fire_long_press(VOL_DOWN);
    end else if (it.code != vol_code[VOL_UP] && it.code != vol_code[VOL_DOWN]) begin
      emit_event(it.code, it.pressed, 1'b1);
    end else begin
      // equal volume codes resolve to up
      k = (it.code == vol_code[VOL_UP]) ? VOL_UP : VOL_DOWN;
      held[k] = it.pressed;
      if (it.pressed) begin
        ticks_left[k] = (long_ticks == '0) ? TICKS_W'(1) : long_ticks;
      end else if (long_mark[k]) begin
        long_mark[k] = 1'b0;
      end else begin
        ticks_left[k] = '0;
        emit_event(it.code, 1'b1, 1'b0);
        emit_event(it.code, 1'b0, 1'b1);
      end
    end
  endtask

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LONG_PRESS_TICKS: long_ticks          = data[TICKS_W-1:0];
      REG_VOL_UP_CODE:      vol_code[VOL_UP]    = data[CODE_W-1:0];
      REG_VOL_DOWN_CODE:    vol_code[VOL_DOWN]  = data[CODE_W-1:0];
      REG_HOME_CODE:        home_code           = data[CODE_W-1:0];
      REG_BACK_CODE:        back_code           = data[CODE_W-1:0];
      REG_MENU_CODE:        menu_code           = data[CODE_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got, want;
    key_item_t it;
    if (!rst_n) begin
      in_taken <= 1'b0;
      long_ticks = RST_LONG_PRESS_TICKS;
      vol_code[VOL_UP]   = RST_VOL_UP_CODE;
      vol_code[VOL_DOWN] = RST_VOL_DOWN_CODE;
      home_code = RST_HOME_CODE;
      back_code = RST_BACK_CODE;
      menu_code = RST_MENU_CODE;
      held       = '{1'b0, 1'b0};
      long_mark  = '{1'b0, 1'b0};
      ticks_left = '{'0, '0};
    end else begin
      in_taken <= in_tvalid && in_tready;
      // results first: an item taken at this edge cannot have produced them yet
      if (out_tvalid && out_tready) begin
        events_seen++;
        got.code  = out_tdata[CODE_W-1:0];
        got.value = out_tdata[CODE_W];
        got.last  = out_tlast;
        if (expected_events.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected event, expected none, got code %0d value %0d last %0d",
                     $time, got.code, got.value, got.last);
        end else begin
          want = expected_events.pop_front();
          if (got.code != want.code) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: event_code mismatch, expected %0d, got %0d",
                       $time, want.code, got.code);
          end
          if (got.value != want.value) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: event_value mismatch, expected %0d, got %0d",
                       $time, want.value, got.value);
          end
          if (got.last != want.last) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: last mismatch, expected %0d, got %0d",
                       $time, want.last, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        apply_reg_write(cfg_index, cfg_data);
      end
      if (in_tvalid && in_tready) begin
        items_taken++;
        it.mode    = in_tuser[0];
        it.code    = in_tdata[CODE_W-1:0];
        it.pressed = in_tdata[CODE_W];
        remap_key_item(it);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: input stream changes on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    key_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // item still on offer, hold it
    end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      it = pending_items.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= it.mode;
      in_tdata  <= {{(TDATA_W-CODE_W-1){1'b0}}, it.pressed, it.code};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // long receiver hold-off, counted here so the driver keeps offering meanwhile
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [CODE_W-1:0] stim_up, stim_down;

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [TICKS_W-1:0] ticks, input logic [CODE_W-1:0] up,
                           input logic [CODE_W-1:0] down, input logic [CODE_W-1:0] home,
                           input logic [CODE_W-1:0] back, input logic [CODE_W-1:0] menu);
    write_reg(REG_LONG_PRESS_TICKS, CFG_DATA_W'(ticks));
    write_reg(REG_VOL_UP_CODE, CFG_DATA_W'(up));
    write_reg(REG_VOL_DOWN_CODE, CFG_DATA_W'(down));
    write_reg(REG_HOME_CODE, CFG_DATA_W'(home));
    write_reg(REG_BACK_CODE, CFG_DATA_W'(back));
    write_reg(REG_MENU_CODE, CFG_DATA_W'(menu));
    @(negedge clk);
    cfg_valid <= 1'b0;
    stim_up   = up;
    stim_down = down;
  endtask

  // wait for all items taken and all events back, then let the pipe settle
  task automatic drain;
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_events.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic add_key(input logic [CODE_W-1:0] code, input logic pressed);
    key_item_t it;
    it.mode    = MODE_KEY;
    it.code    = code;
    it.pressed = pressed;
    pending_items.push_back(it);
  endtask

  // tick items carry junk in the ignored fields
  task automatic add_tick;
    key_item_t it;
    it.mode    = MODE_TICK;
    it.code    = CODE_W'($urandom_range(767));
    it.pressed = 1'($urandom_range(1));
    pending_items.push_back(it);
  endtask

  // mostly volume-key traffic with ticks mixed in, some other keys as noise
  task automatic add_random(input int n, input int tick_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < tick_pct) add_tick();
      else if (r < 88) add_key($urandom_range(1) ? stim_up : stim_down,
                               1'($urandom_range(1)));
      else add_key(CODE_W'($urandom_range(767)), 1'($urandom_range(1)));
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: pass-through extremes, short presses, idle tick
    add_key(10'd0, 1'b1);
    add_key(10'd767, 1'b0);
    add_key(10'd512, 1'b1);
    add_key(RST_VOL_UP_CODE, 1'b1);
    add_key(RST_VOL_UP_CODE, 1'b0);
    add_key(RST_VOL_DOWN_CODE, 1'b0);   // release never seen pressed
    add_tick();
    drain();

    // two-tick countdown: expiry paths
    configure(16'd2, RST_VOL_UP_CODE, RST_VOL_DOWN_CODE, RST_HOME_CODE, RST_BACK_CODE,
              RST_MENU_CODE);
    add_key(stim_up, 1'b1);   add_tick(); add_tick();     // home
    add_key(stim_up, 1'b0);                                // clears mark only
    add_key(stim_down, 1'b1); add_tick();
    add_key(stim_down, 1'b0); add_tick();                  // short release, then nothing
    add_key(stim_up, 1'b1);   add_key(stim_down, 1'b1);
    add_tick(); add_tick();                                // both expire: menu via up
    add_key(stim_down, 1'b0); add_key(stim_up, 1'b0);
    add_key(stim_up, 1'b1);   add_tick(); add_tick();     // home, mark set
    add_key(stim_up, 1'b1);                                // re-arm, mark kept
    add_key(stim_up, 1'b0);                                // mark cleared, countdown runs on
    add_tick(); add_tick();                                // expiry with key released
    drain();

    // shortest countdown, no idling, long receiver hold-off to back up the input
    configure(16'd1, CODE_W'($urandom_range(767)), CODE_W'($urandom_range(767)),
              CODE_W'($urandom_range(767)), CODE_W'($urandom_range(767)),
              CODE_W'($urandom_range(767)));
    set_idling(0, 0);
    @(posedge clk);
    hold_req++;
    add_random(120, 25);
    drain();

    // zero ticks arms with one; both volume keys share a code
    configure(16'd0, 10'd300, 10'd300, 10'd1, 10'd2, 10'd3);
    set_idling(58, 0);
    add_random(120, 25);
    drain();

    // code extremes
    configure(16'd3, 10'd0, 10'd767, 10'd767, 10'd0, 10'd512);
    set_idling(0, 58);
    add_random(120, 25);
    drain();

    configure(16'd5, CODE_W'($urandom_range(767)), CODE_W'($urandom_range(767)),
              CODE_W'($urandom_range(767)), CODE_W'($urandom_range(767)),
              CODE_W'($urandom_range(767)));
    set_idling(29, 29);
    add_random(120, 30);
    drain();

    // longest countdown: a run of ticks must not fire, release is a short press
    configure(16'hFFFF, RST_VOL_UP_CODE, RST_VOL_DOWN_CODE, RST_HOME_CODE, RST_BACK_CODE,
              RST_MENU_CODE);
    set_idling(0, 0);
    add_key(stim_down, 1'b1);
    repeat (40) add_tick();
    add_key(stim_down, 1'b0);
    add_key(stim_up, 1'b1);
    add_key(stim_up, 1'b0);
    drain();

    if (expected_events.size() != 0) begin
      errors++;
      $display("%0t: %0d expected events never arrived", $time, expected_events.size());
    end
    $display("Run covered %0d key/tick items, %0d output events and %0d register writes,",
             items_taken, events_seen, cfg_writes);
    $display("over seven register settings with idle and stall phases on both streams.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #(12 * 600000);
    $display("Some tests failed");
    $finish;
  end

endmodule
